/* rtl/b2y_pkg.sv */
// Shared types, constants and helpers for the BGR to YUV 4:2:0 converter.
`default_nettype none

package b2y_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = PIX_W + 1;
    localparam int COUNT_W    = 12;
    localparam int SIZE_W     = 13;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int STORE_AW   = $clog2(STORE_DEPTH);
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pix_t;

    // Component sums of one horizontal pixel pair (red in the top bits).
    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } pair_sum_t;

    // Registered input stage handed to the arithmetic stages.
    typedef struct packed {
        logic      valid;
        logic      chroma;
        pix_t      pix;
        pair_sum_t pair;
    } stage1_t;

    // Clear bit 0, then clamp to 2..max_size.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] max_size);
        logic [SIZE_W-1:0] t;
        t = {v[SIZE_W-1:1], 1'b0};
        if (t < SIZE_W'(2)) begin
            t = SIZE_W'(2);
        end
        if (t > max_size) begin
            t = max_size;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

/* rtl/b2y_line_store.sv */
// Line store holding the pair sums of the last even row.
`default_nettype none

module b2y_line_store
    import b2y_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                wr_en,
    input  wire logic                rd_en,
    input  wire logic [STORE_AW-1:0] addr,
    input  wire pair_sum_t           wr_data,
    output pair_sum_t                rd_data
);

    pair_sum_t mem [STORE_DEPTH];
    pair_sum_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/b2y_pixel_math.sv */
// Luma and cluster chroma arithmetic: averaging/luma stage, then chroma and result register.
`default_nettype none

module b2y_pixel_math
    import b2y_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire stage1_t          st1,
    input  wire pair_sum_t        stored,
    output logic                  out_valid,
    output logic [PIX_W-1:0]      out_luma,
    output logic [PIX_W-1:0]      out_u,
    output logic [PIX_W-1:0]      out_v,
    output logic                  out_chroma
);

    localparam int LSUM_W = 2 * PIX_W;
    localparam int CSUM_W = 2 * PIX_W + 1;

    logic              s2_valid_reg;
    logic              s2_chroma_reg;
    logic [PIX_W-1:0]  s2_luma_reg;
    logic [PIX_W-1:0]  s2_r_reg, s2_g_reg, s2_b_reg;

    logic              out_valid_reg;
    logic              out_chroma_reg;
    logic [PIX_W-1:0]  out_luma_reg, out_u_reg, out_v_reg;

    logic [LSUM_W-1:0] luma_sum;
    logic [SUM_W:0]    quad_r, quad_g, quad_b;

    logic signed [CSUM_W-1:0] ra_s, ga_s, ba_s;
    logic signed [CSUM_W-1:0] u_n, v_n, u_off, v_off;

    always_comb begin
        luma_sum = LSUM_W'(st1.pix.red)   * LSUM_W'(77)
                 + LSUM_W'(st1.pix.green) * LSUM_W'(150)
                 + LSUM_W'(st1.pix.blue)  * LSUM_W'(29);
        quad_r = (SUM_W+1)'(st1.pair.red)   + (SUM_W+1)'(stored.red);
        quad_g = (SUM_W+1)'(st1.pair.green) + (SUM_W+1)'(stored.green);
        quad_b = (SUM_W+1)'(st1.pair.blue)  + (SUM_W+1)'(stored.blue);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= st1.valid;
        end
        if (advance) begin
            s2_chroma_reg <= st1.chroma;
            s2_luma_reg   <= luma_sum[LSUM_W-1:PIX_W];
            s2_r_reg      <= quad_r[SUM_W:2];
            s2_g_reg      <= quad_g[SUM_W:2];
            s2_b_reg      <= quad_b[SUM_W:2];
        end
    end

    // Offset of 128 after a flooring >>8 equals adding 32768 before it.
    always_comb begin
        ra_s  = $signed(CSUM_W'(s2_r_reg));
        ga_s  = $signed(CSUM_W'(s2_g_reg));
        ba_s  = $signed(CSUM_W'(s2_b_reg));
        u_n   = CSUM_W'(128) * ba_s - CSUM_W'(43) * ra_s - CSUM_W'(85) * ga_s;
        v_n   = CSUM_W'(128) * ra_s - CSUM_W'(107) * ga_s - CSUM_W'(21) * ba_s;
        u_off = u_n + $signed(CSUM_W'(32768));
        v_off = v_n + $signed(CSUM_W'(32768));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= s2_valid_reg;
        end
        if (advance) begin
            out_chroma_reg <= s2_chroma_reg;
            out_luma_reg   <= s2_luma_reg;
            out_u_reg      <= s2_chroma_reg ? u_off[2*PIX_W-1:PIX_W] : '0;
            out_v_reg      <= s2_chroma_reg ? v_off[2*PIX_W-1:PIX_W] : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_luma   = out_luma_reg;
    assign out_u      = out_u_reg;
    assign out_v      = out_v_reg;
    assign out_chroma = out_chroma_reg;

endmodule

`default_nettype wire

/* rtl/bgr_to_yuv420_converter.sv */
// Top level: stream ports, frame position counters, pair capture and line store access.
`default_nettype none

// BGR pixels come in raster order, one per beat, and each gives one result
// beat: its luma, plus U and V on the odd-row, odd-column pixel that closes a
// 2x2 cluster (chroma_valid in tuser, U and V zero otherwise). One pixel per
// clock is sustained while m_tready does not stall the output; a pixel passes
// the input/line-store read register, the averaging and luma register and the
// result register in turn. Pair sums of even rows sit in a 2048-entry line
// store that is written and read at the pixel's acceptance. A write to either
// size register restarts the frame at the top-left pixel; sizes are forced
// even and clamped to 2..4096.
module bgr_to_yuv420_converter
    import b2y_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data,
    // pixel input
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,  // blue[7:0], green[15:8], red[23:16]
    // result output
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [23:0]               m_tdata,  // luma[7:0], chroma_u[15:8], chroma_v[23:16]
    output logic [0:0]                m_tuser   // chroma_valid[0]
);

    logic [SIZE_W-1:0]  width_reg, height_reg;
    logic [COUNT_W-1:0] col_reg, row_reg;
    pix_t               left_hold_reg;
    stage1_t            st1_reg;

    logic               advance, accept;
    pix_t               pix_in;
    pair_sum_t          pair_now, stored;
    logic [SIZE_W-1:0]  w_eff, h_eff;
    logic [SIZE_W-1:0]  col_inc, row_inc;
    logic               store_wr;

    logic               out_valid, out_chroma;
    logic [PIX_W-1:0]   out_luma, out_u, out_v;

    assign pix_in.blue  = s_tdata[PIX_W-1:0];
    assign pix_in.green = s_tdata[2*PIX_W-1:PIX_W];
    assign pix_in.red   = s_tdata[3*PIX_W-1:2*PIX_W];

    assign advance   = !out_valid || m_tready;
    assign s_tready  = advance;
    assign accept    = s_tvalid && advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        w_eff   = eff_size(width_reg, SIZE_W'(MAX_WIDTH));
        h_eff   = eff_size(height_reg, SIZE_W'(MAX_HEIGHT));
        col_inc = SIZE_W'(col_reg) + SIZE_W'(1);
        row_inc = SIZE_W'(row_reg) + SIZE_W'(1);
        pair_now.red   = SUM_W'(pix_in.red)   + SUM_W'(left_hold_reg.red);
        pair_now.green = SUM_W'(pix_in.green) + SUM_W'(left_hold_reg.green);
        pair_now.blue  = SUM_W'(pix_in.blue)  + SUM_W'(left_hold_reg.blue);
        store_wr = accept && col_reg[0] && !row_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= SIZE_W'(640);
            height_reg    <= SIZE_W'(480);
            col_reg       <= '0;
            row_reg       <= '0;
            left_hold_reg <= '0;
            st1_reg.valid <= 1'b0;
        end else begin
            if (advance) begin
                st1_reg.valid <= accept;
            end
            if (accept) begin
                if (!col_reg[0]) begin
                    left_hold_reg <= pix_in;
                end
                if (col_inc >= w_eff) begin
                    col_reg <= '0;
                    row_reg <= (row_inc >= h_eff) ? '0 : row_inc[COUNT_W-1:0];
                end else begin
                    col_reg <= col_inc[COUNT_W-1:0];
                end
            end
            if (cfg_valid) begin
                case (cfg_index)
                    REG_FRAME_WIDTH: begin
                        width_reg <= cfg_data;
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    REG_FRAME_HEIGHT: begin
                        height_reg <= cfg_data;
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (accept) begin
            st1_reg.chroma <= col_reg[0] && row_reg[0];
            st1_reg.pix    <= pix_in;
            st1_reg.pair   <= pair_now;
        end
    end

    b2y_line_store u_line_store (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .rd_en   (accept),
        .addr    (col_reg[COUNT_W-1:1]),
        .wr_data (pair_now),
        .rd_data (stored)
    );

    b2y_pixel_math u_pixel_math (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .st1        (st1_reg),
        .stored     (stored),
        .out_valid  (out_valid),
        .out_luma   (out_luma),
        .out_u      (out_u),
        .out_v      (out_v),
        .out_chroma (out_chroma)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {out_v, out_u, out_luma};
    assign m_tuser  = out_chroma;

endmodule

`default_nettype wire

/* verif/yuv420_result_checker.sv */
// Watches the converter's channels, predicts every result beat and compares.
module yuv420_result_checker
    import b2y_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [23:0]          s_tdata,  // blue[7:0], green[15:8], red[23:16]
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [23:0]          m_tdata,  // luma[7:0], chroma_u[15:8], chroma_v[23:16]
    input  wire logic [0:0]           m_tuser,  // chroma_valid[0]
    output int                        fail_count,
    output int                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             chroma_valid;
        logic [PIX_W-1:0] chroma_v;
        logic [PIX_W-1:0] chroma_u;
        logic [PIX_W-1:0] luma;
    } yuv_beat_t;

    logic [SIZE_W-1:0] width_cfg;
    logic [SIZE_W-1:0] height_cfg;
    int unsigned       col;
    int unsigned       row;
    pix_t              held_left;
    pair_sum_t         row_pair_sums [STORE_DEPTH];
    yuv_beat_t         awaited_beats [$];
    yuv_beat_t         want;
    yuv_beat_t         got;

    function automatic int unsigned even_clamped(input logic [SIZE_W-1:0] raw,
                                                 input int unsigned ceiling);
        int unsigned e;
        e = {raw[SIZE_W-1:1], 1'b0};
        if (e < 2) begin
            e = 2;
        end else if (e > ceiling) begin
            e = ceiling;
        end
        return e;
    endfunction

    // floor(n / 256) + 128, n never leaves [-32640, 32640]
    function automatic logic [PIX_W-1:0] chroma_level(input int n);
        return PIX_W'((n >>> 8) + 128);
    endfunction

    task automatic predict_beat(input pix_t px, output yuv_beat_t beat);
        int unsigned eff_w;
        int unsigned eff_h;
        pair_sum_t   pair;
        pair_sum_t   above;
        int          r_avg;
        int          g_avg;
        int          b_avg;
        eff_w = even_clamped(width_cfg, MAX_WIDTH);
        eff_h = even_clamped(height_cfg, MAX_HEIGHT);
        beat = '0;
        beat.luma = PIX_W'((77 * int'(px.red) + 150 * int'(px.green)
                            + 29 * int'(px.blue)) >> 8);
        if (col[0] == 1'b0) begin
            held_left = px;
        end else begin
            pair.red   = SUM_W'(px.red) + SUM_W'(held_left.red);
            pair.green = SUM_W'(px.green) + SUM_W'(held_left.green);
            pair.blue  = SUM_W'(px.blue) + SUM_W'(held_left.blue);
            if (row[0] == 1'b0) begin
                row_pair_sums[col / 2] = pair;
            end else begin
                above = row_pair_sums[col / 2];
                r_avg = (int'(pair.red) + int'(above.red)) / 4;
                g_avg = (int'(pair.green) + int'(above.green)) / 4;
                b_avg = (int'(pair.blue) + int'(above.blue)) / 4;
                beat.chroma_u     = chroma_level(-43 * r_avg - 85 * g_avg + 128 * b_avg);
                beat.chroma_v     = chroma_level(128 * r_avg - 107 * g_avg - 21 * b_avg);
                beat.chroma_valid = 1'b1;
            end
        end
        col++;
        if (col >= eff_w) begin
            col = 0;
            row++;
            if (row >= eff_h) begin
                row = 0;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg  = SIZE_W'(640);
            height_cfg = SIZE_W'(480);
            col        = 0;
            row        = 0;
            held_left  = '0;
            fail_count = 0;
            awaited_beats.delete();
            outstanding <= 0;
        end else begin
            // size writes restart the frame; unknown indexes leave everything alone
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_FRAME_WIDTH) begin
                    width_cfg = cfg_data;
                    col = 0;
                    row = 0;
                end else if (cfg_index == REG_FRAME_HEIGHT) begin
                    height_cfg = cfg_data;
                    col = 0;
                    row = 0;
                end
            end
            if (s_tvalid && s_tready) begin
                predict_beat(s_tdata, want);
                awaited_beats.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tdata};
                if (awaited_beats.size() == 0) begin
                    $display("%0t: unexpected result beat y=%0d u=%0d v=%0d cv=%0b", $time,
                             got.luma, got.chroma_u, got.chroma_v, got.chroma_valid);
                    fail_count++;
                end else begin
                    want = awaited_beats.pop_front();
                    if (got !== want) begin
                        $display({"%0t: expected y=%0d u=%0d v=%0d cv=%0b,",
                                  " got y=%0d u=%0d v=%0d cv=%0b"}, $time,
                                 want.luma, want.chroma_u, want.chroma_v, want.chroma_valid,
                                 got.luma, got.chroma_u, got.chroma_v, got.chroma_valid);
                        fail_count++;
                    end
                end
            end
            outstanding <= awaited_beats.size();
        end
    end

endmodule

/* verif/tb_bgr_to_yuv420_converter.sv */
// Testbench top for the BGR to YUV 4:2:0 converter: clock, reset, stimulus and verdict.
module tb_bgr_to_yuv420_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import b2y_pkg::*;

    localparam int RANDOM_PIXELS   = 680;
    localparam int HEADROOM_CYCLES = 8;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;
    logic [0:0]           m_tuser;
    int                   fail_count;
    int                   outstanding;
    int                   src_idle_pct = 10;
    int                   snk_idle_pct = 56;

    bgr_to_yuv420_converter u_top (.*);

    yuv420_result_checker u_checker (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    initial begin
        #20_000_000;
        $display("[bgr_to_yuv420_converter] ERROR");
        $finish;
    end

    // some pixels with every component at 0 or 255
    function automatic pix_t random_pixel();
        pix_t p;
        p = pix_t'(24'($urandom));
        if ($urandom_range(0, 3) == 0) begin
            p.red   = {PIX_W{p.red[0]}};
            p.green = {PIX_W{p.green[0]}};
            p.blue  = {PIX_W{p.blue[0]}};
        end
        return p;
    endfunction

    // valid stays high into the next beat unless a gap is drawn
    task automatic send_pixel(input pix_t px);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_frame(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        drain();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned cur_w;
        int unsigned cur_h;
        int unsigned eff_w;
        int unsigned eff_h;
        int unsigned n;
        int unsigned bad_at;
        int          done;
        pix_t        px;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset sizes (640 wide): start of the first row, no early wrap
        repeat (48) send_pixel(random_pixel());

        // sizes below range clamp to 2x2; every four pixels close a cluster and a frame
        set_frame('0, SIZE_W'(1));
        cur_w = 0;
        cur_h = 1;
        for (int c = 0; c < 6; c++) begin
            for (int k = 0; k < 4; k++) begin
                case (c)
                    0: px = '0;
                    1: px = '1;
                    2: px = '{red: 8'hFF, green: 8'h00, blue: 8'h00};
                    3: px = '{red: 8'h00, green: 8'h00, blue: 8'hFF};
                    4: px = '{red: 8'h00, green: 8'hFF, blue: 8'h00};
                    default: px = (k == 3) ? pix_t'('1) : pix_t'(24'hFF << (8 * k));
                endcase
                send_pixel(px);
            end
        end

        // small random frames, often cut short so the next size write restarts mid-frame
        done = 0;
        while (done < RANDOM_PIXELS) begin
            if (done >= 2 * RANDOM_PIXELS / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else if (done >= RANDOM_PIXELS / 3) begin
                src_idle_pct = 56;
                snk_idle_pct = 10;
            end
            if ($urandom_range(0, 4) != 0) begin
                drain();
                if ($urandom_range(0, 3) != 0) begin
                    cur_w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1)
                                                        : $urandom_range(2, 24);
                    write_reg(REG_FRAME_WIDTH, SIZE_W'(cur_w));
                end
                if ($urandom_range(0, 3) != 0) begin
                    cur_h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1)
                                                        : $urandom_range(2, 10);
                    write_reg(REG_FRAME_HEIGHT, SIZE_W'(cur_h));
                end
                cfg_valid <= 1'b0;
            end
            eff_w = (cur_w < 2) ? 2 : (cur_w & ~32'd1);
            eff_h = (cur_h < 2) ? 2 : (cur_h & ~32'd1);
            n = eff_w * eff_h * $urandom_range(0, 2) + $urandom_range(1, 2 * eff_w);
            bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : n;
            for (int i = 0; i < n; i++) begin
                // a write to an unknown index must not disturb the frame position
                if (i == bad_at) begin
                    drain();
                    write_reg(CFG_IDX_W'($urandom_range(REG_FRAME_HEIGHT + 1,
                                                        {CFG_IDX_W{1'b1}})),
                              SIZE_W'($urandom));
                    cfg_valid <= 1'b0;
                end
                send_pixel(random_pixel());
            end
            done += n;
        end

        // widest line: no wrap within the first columns
        set_frame(SIZE_W'(MAX_WIDTH), SIZE_W'(2));
        repeat (40) send_pixel(random_pixel());
        // all-ones width clamps to the maximum
        set_frame('1, SIZE_W'(MAX_HEIGHT));
        repeat (20) send_pixel(random_pixel());
        // all-ones height clamps to the maximum: many rows without a frame wrap
        set_frame(SIZE_W'(2), '1);
        repeat (40) send_pixel(random_pixel());

        drain();
        repeat (HEADROOM_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[bgr_to_yuv420_converter] OK");
        end else begin
            $display("[bgr_to_yuv420_converter] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/b2y_pkg.sv
rtl/b2y_line_store.sv
rtl/b2y_pixel_math.sv
rtl/bgr_to_yuv420_converter.sv
verif/yuv420_result_checker.sv
verif/tb_bgr_to_yuv420_converter.sv
